### sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define SFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// An implication whose consequent is checked at the next clock edge.
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

   localparam int COUNT_LIMIT_DEFAULT = 5;
   localparam int ROOT_STEPS          = 15;

   localparam logic [9:0]  UPPER_RESET = 10'd15;
   localparam logic [9:0]  LOWER_RESET = 10'd10;
   localparam logic [9:0]  REST_RESET  = 10'd338;
   localparam logic [14:0] ENTER_RESET = 15'd160;
   localparam logic [14:0] EXIT_RESET  = 15'd320;

   localparam logic [2:0] CSR_SHAKE_UPPER = 3'd0;
   localparam logic [2:0] CSR_SHAKE_LOWER = 3'd1;
   localparam logic [2:0] CSR_REST_LEVEL  = 3'd2;
   localparam logic [2:0] CSR_FALL_ENTER  = 3'd3;
   localparam logic [2:0] CSR_FALL_EXIT   = 3'd4;

   localparam logic [1:0] ST_NONE   = 2'd0;
   localparam logic [1:0] ST_ACTIVE = 2'd1;
   localparam logic [1:0] ST_ENDED  = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic       load;
      logic       square;
      logic [1:0] axis_sel;
      logic       root_init;
      logic       root_step;
      logic       scale;
      logic       mul;
      logic       finish;
   } sfd_cmd_type;

   typedef struct packed {
      logic out_full;
   } sfd_status_type;

endpackage
`default_nettype wire

### sv/sfd_controller.sv
`default_nettype none
module sfd_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire sfd_pkg::sfd_status_type status,
   output sfd_pkg::sfd_cmd_type         cmd
);
   import sfd_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SQUARE = 3'd1;
   localparam logic [2:0] S_PREP   = 3'd2;
   localparam logic [2:0] S_ROOT   = 3'd3;
   localparam logic [2:0] S_SCALE  = 3'd4;
   localparam logic [2:0] S_MUL    = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   localparam int SW = $clog2(ROOT_STEPS);
   localparam logic [SW-1:0] ROOT_LAST = SW'(ROOT_STEPS - 1);
   localparam logic [SW-1:0] SQ_LAST   = SW'(2);

   logic [2:0]    state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.axis_sel = step_ff[1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            if (step_ff == SQ_LAST) begin
               step_in  = '0;
               state_in = S_PREP;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_PREP: begin
            cmd.root_init = 1'b1;
            state_in      = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (step_ff == ROOT_LAST) begin
               step_in  = '0;
               state_in = S_SCALE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!status.out_full) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule
`default_nettype wire

### sv/sfd_datapath.sv
`default_nettype none
module sfd_datapath #(
   parameter int COUNT_LIMIT = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sfd_pkg::sfd_cmd_type cmd,
   output sfd_pkg::sfd_status_type   status,
   input  wire logic [9:0]           req_accel_x,
   input  wire logic [9:0]           req_accel_y,
   input  wire logic [9:0]           req_accel_z,
   input  wire logic                 csr_valid,
   input  wire logic [2:0]           csr_index,
   input  wire logic [14:0]          csr_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_shake_status,
   output logic [14:0]               rsp_shake_strength,
   output logic [1:0]                rsp_shake_axis,
   output logic [1:0]                rsp_fall_status
);
   import sfd_pkg::*;

   localparam int CW = $clog2(COUNT_LIMIT + 1);
   localparam logic [CW-1:0] LIMIT = CW'(COUNT_LIMIT);

   function automatic logic [9:0] abs_diff(input logic [9:0] a, input logic [9:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   function automatic logic two_of_three(input logic a, input logic b, input logic c);
      return (a & b) | (a & c) | (b & c);
   endfunction

   logic [9:0]  upper_ff, lower_ff, rest_ff;
   logic [14:0] enter_ff, exit_ff;

   logic [9:0]  prev_x_ff, prev_y_ff, prev_z_ff;
   logic [9:0]  dx_ff, dy_ff, dz_ff;
   logic        upper_hit_ff, lower_hit_ff;
   logic [1:0]  axis_ff;
   logic [21:0] sum_ff;
   logic [29:0] v_ff, root_ff, bit_ff;
   logic [18:0] x_ff;
   logic [33:0] prod_ff;

   logic [CW-1:0] count_ff;
   logic          shaking_ff, falling_ff;
   logic [14:0]   filt_ff;

   logic        rsp_valid_ff;
   logic [1:0]  sstat_ff, axis_out_ff, fstat_ff;
   logic [14:0] strength_ff;

   logic [9:0]  d_sel;
   logic [19:0] square;
   logic [30:0] trial;
   logic        take;
   logic [14:0] mag;
   logic [1:0]  axis_in;
   logic [14:0] q0, q;
   logic [18:0] rem;

   logic          start;
   logic [CW-1:0] count_up, count_in;
   logic          shaking_in, falling_in;
   logic [14:0]   filt_up, filt_in;
   logic [1:0]    sstat_in, fstat_in;

   assign status.out_full = rsp_valid_ff & rsp_stall;

   always_comb begin
      case (cmd.axis_sel)
         AXIS_X:  d_sel = dx_ff;
         AXIS_Y:  d_sel = dy_ff;
         AXIS_Z:  d_sel = dz_ff;
         default: d_sel = '0;
      endcase
   end

   assign square = d_sel * d_sel;
   assign trial  = {1'b0, root_ff} + {1'b0, bit_ff};
   assign take   = ({1'b0, v_ff} >= trial);
   assign mag    = root_ff[14:0];

   always_comb begin
      axis_in = AXIS_X;
      if (req_accel_y > req_accel_x) axis_in = AXIS_Y;
      if (req_accel_z > ((axis_in == AXIS_Y) ? req_accel_y : req_accel_x)) axis_in = AXIS_Z;
   end

   assign q0  = prod_ff[32:18];
   assign rem = x_ff - ({1'b0, q0, 3'b000} + {3'b000, q0, 1'b0});
   assign q   = (rem >= 19'd10) ? (q0 + 15'd1) : q0;

   always_comb begin
      start      = upper_hit_ff & ~shaking_ff & ~falling_ff & (count_ff == LIMIT);
      count_up   = count_ff;
      filt_up    = filt_ff;
      count_in   = count_ff;
      shaking_in = shaking_ff;
      filt_in    = filt_ff;
      sstat_in   = ST_NONE;
      if (start) begin
         shaking_in = 1'b1;
         filt_in    = q;
         sstat_in   = ST_ACTIVE;
      end else begin
         if (upper_hit_ff) begin
            count_up = (count_ff < LIMIT) ? (count_ff + 1'b1) : LIMIT;
            filt_up  = q;
         end
         count_in = count_up;
         filt_in  = filt_up;
         if (shaking_ff && (count_up == '0)) begin
            shaking_in = 1'b0;
            filt_in    = '0;
            sstat_in   = ST_ENDED;
         end else begin
            if (!lower_hit_ff && (count_up != '0)) count_in = count_up - 1'b1;
            sstat_in = shaking_ff ? ST_ACTIVE : ST_NONE;
         end
      end

      falling_in = falling_ff;
      if (!falling_ff && (mag < enter_ff)) begin
         falling_in = 1'b1;
         fstat_in   = ST_ACTIVE;
      end else if (falling_ff && (mag > exit_ff)) begin
         falling_in = 1'b0;
         fstat_in   = ST_ENDED;
      end else begin
         fstat_in = falling_ff ? ST_ACTIVE : ST_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff        <= abs_diff(req_accel_x, rest_ff);
         dy_ff        <= abs_diff(req_accel_y, rest_ff);
         dz_ff        <= abs_diff(req_accel_z, rest_ff);
         upper_hit_ff <= two_of_three(abs_diff(req_accel_x, prev_x_ff) > upper_ff,
                                      abs_diff(req_accel_y, prev_y_ff) > upper_ff,
                                      abs_diff(req_accel_z, prev_z_ff) > upper_ff);
         lower_hit_ff <= two_of_three(abs_diff(req_accel_x, prev_x_ff) > lower_ff,
                                      abs_diff(req_accel_y, prev_y_ff) > lower_ff,
                                      abs_diff(req_accel_z, prev_z_ff) > lower_ff);
         axis_ff      <= axis_in;
         sum_ff       <= '0;
      end
      if (cmd.square) begin
         sum_ff <= sum_ff + {2'b00, square};
      end
      if (cmd.root_init) begin
         v_ff    <= {sum_ff, 8'h00};
         root_ff <= '0;
         bit_ff  <= 30'h1000_0000;
      end
      if (cmd.root_step) begin
         if (take) begin
            v_ff    <= v_ff - trial[29:0];
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.scale) begin
         x_ff <= {1'b0, mag, 3'b000} - {3'b000, mag, 1'b0} + {2'b00, filt_ff, 2'b00} + 19'd5;
      end
      if (cmd.mul) begin
         prod_ff <= x_ff * 15'd26214;
      end
      if (cmd.finish) begin
         sstat_ff    <= sstat_in;
         strength_ff <= (sstat_in == ST_ACTIVE) ? filt_in : 15'd0;
         axis_out_ff <= axis_ff;
         fstat_ff    <= fstat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff     <= UPPER_RESET;
         lower_ff     <= LOWER_RESET;
         rest_ff      <= REST_RESET;
         enter_ff     <= ENTER_RESET;
         exit_ff      <= EXIT_RESET;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         count_ff     <= '0;
         shaking_ff   <= 1'b0;
         falling_ff   <= 1'b0;
         filt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SHAKE_UPPER: upper_ff <= csr_data[9:0];
               CSR_SHAKE_LOWER: lower_ff <= csr_data[9:0];
               CSR_REST_LEVEL:  rest_ff  <= csr_data[9:0];
               CSR_FALL_ENTER:  enter_ff <= csr_data;
               CSR_FALL_EXIT:   exit_ff  <= csr_data;
               default: begin
               end
            endcase
         end
         if (cmd.load) begin
            prev_x_ff <= req_accel_x;
            prev_y_ff <= req_accel_y;
            prev_z_ff <= req_accel_z;
         end
         if (cmd.finish) begin
            count_ff     <= count_in;
            shaking_ff   <= shaking_in;
            falling_ff   <= falling_in;
            filt_ff      <= filt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_shake_status   = sstat_ff;
   assign rsp_shake_strength = strength_ff;
   assign rsp_shake_axis     = axis_out_ff;
   assign rsp_fall_status    = fstat_ff;

endmodule
`default_nettype wire

### sv/shake_and_freefall_detector.sv
// Shake and free-fall detector for a three-axis accelerometer. Each request word carries one
// raw 10-bit sample per axis and yields exactly one response word with shake status, filtered
// magnitude (Q.4), dominant axis and free-fall status. One word is processed at a time: the
// next request is taken once the last word is done, and a word cannot finish while the
// previous response is held by a stalled receiver. Processing time is set by the three
// squarings on one shared squarer and the 15-step iterative square root; a finished response
// waits in its output register without blocking acceptance of the next request. The
// configuration port is always ready and should be written only while the block is idle.
`default_nettype none
module shake_and_freefall_detector #(
   parameter int COUNT_LIMIT = sfd_pkg::COUNT_LIMIT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [9:0]  req_accel_x,
   input  wire logic [9:0]  req_accel_y,
   input  wire logic [9:0]  req_accel_z,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_shake_status,
   output logic [14:0]      rsp_shake_strength,
   output logic [1:0]       rsp_shake_axis,
   output logic [1:0]       rsp_fall_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [14:0] csr_data
);
   import sfd_pkg::*;

   sfd_cmd_type    cmd;
   sfd_status_type status;

   assign csr_ready = 1'b1;

   sfd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sfd_datapath #(
      .COUNT_LIMIT (COUNT_LIMIT)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_accel_x        (req_accel_x),
      .req_accel_y        (req_accel_y),
      .req_accel_z        (req_accel_z),
      .csr_valid          (csr_valid & csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_shake_status   (rsp_shake_status),
      .rsp_shake_strength (rsp_shake_strength),
      .rsp_shake_axis     (rsp_shake_axis),
      .rsp_fall_status    (rsp_fall_status)
   );

endmodule
`default_nettype wire

### sv/sfd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module sfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_shake_status,
   input wire logic [14:0] rsp_shake_strength,
   input wire logic [1:0]  rsp_shake_axis,
   input wire logic [1:0]  rsp_fall_status
);
   import sfd_pkg::*;

   `SFD_ASSERT(a_strength_only_active, clock, reset, rsp_valid && (rsp_shake_status != ST_ACTIVE) |-> (rsp_shake_strength == 15'd0), "strength must be zero unless shaking is active")
   `SFD_ASSERT(a_codes_in_range, clock, reset, rsp_valid |-> (rsp_shake_status <= ST_ENDED) && (rsp_fall_status <= ST_ENDED) && (rsp_shake_axis <= AXIS_Z), "response word holds an undefined code")
   `SFD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "block must be busy after accepting a word")
   `SFD_ASSERT(a_result_from_work, clock, reset, $rose(rsp_valid) |-> $past(req_stall), "response word appeared without work in progress")
   `SFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_shake_strength), "stalled response word must hold")

endmodule

bind shake_and_freefall_detector sfd_checker u_sfd_checker (.*);
`default_nettype wire

### test/tb_top.sv
`default_nettype none
module tb_top;
   import sfd_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] strength;
      logic [1:0]  axis;
      logic [1:0]  fall;
   } shake_report_t;

   typedef struct packed {
      logic [9:0]    ax;
      logic [9:0]    ay;
      logic [9:0]    az;
      bit            typed;
      shake_report_t report;
   } directed_row_t;

   typedef struct packed {
      logic [14:0] upper;
      logic [14:0] lower;
      logic [14:0] rest;
      logic [14:0] enter;
      logic [14:0] leave;
   } phase_setting_t;

   localparam int SHAKE_COUNT_MAX = COUNT_LIMIT_DEFAULT;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 232;
   localparam int DRAIN_CYCLES    = 30;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam logic [2:0] CSR_UNUSED_LO = 3'd5;

   localparam logic [9:0] LO = 10'd0;
   localparam logic [9:0] HI = 10'd1023;
   localparam logic [9:0] RS = 10'd338;
   localparam shake_report_t NO_REPORT = '0;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [9:0]  req_accel_x = '0;
   logic [9:0]  req_accel_y = '0;
   logic [9:0]  req_accel_z = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_shake_status;
   logic [14:0] rsp_shake_strength;
   logic [1:0]  rsp_shake_axis;
   logic [1:0]  rsp_fall_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [14:0] csr_data = '0;

   shake_and_freefall_detector DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_accel_x(req_accel_x),
      .req_accel_y(req_accel_y),
      .req_accel_z(req_accel_z),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_shake_status(rsp_shake_status),
      .rsp_shake_strength(rsp_shake_strength),
      .rsp_shake_axis(rsp_shake_axis),
      .rsp_fall_status(rsp_fall_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Predictor configuration and state.
   logic [9:0]  upper_thr   = UPPER_RESET;
   logic [9:0]  lower_thr   = LOWER_RESET;
   logic [9:0]  rest_level  = REST_RESET;
   logic [14:0] enter_level = ENTER_RESET;
   logic [14:0] exit_level  = EXIT_RESET;
   logic [9:0]  prev_word [3] = '{10'd0, 10'd0, 10'd0};
   int          shake_count = 0;
   bit          shaking = 1'b0;
   logic [14:0] filtered_q4 = '0;
   bit          falling = 1'b0;

   shake_report_t expected_reports [$];
   logic [9:0]    sent_word [3] = '{10'd0, 10'd0, 10'd0};
   int            burst_left = 0;
   int            mismatch_count = 0;
   int            quiet_cycles = 0;
   int            stall_mode = 0;
   int            stall_span = 0;
   int            cycle_count = 0;

   directed_row_t directed_rows [24] = '{
      '{RS, RS, RS, 1'b1, '{ST_NONE, 15'd0, AXIS_X, ST_ACTIVE}},
      '{HI, HI, HI, 1'b1, '{ST_NONE, 15'd0, AXIS_X, ST_ENDED}},
      '{LO, LO, LO, 1'b1, '{ST_NONE, 15'd0, AXIS_X, ST_NONE}},
      '{HI, HI, HI, 1'b1, '{ST_NONE, 15'd0, AXIS_X, ST_NONE}},
      '{LO, LO, LO, 1'b1, '{ST_NONE, 15'd0, AXIS_X, ST_NONE}},
      '{HI, HI, HI, 1'b0, NO_REPORT},
      '{LO, LO, LO, 1'b0, NO_REPORT},
      '{LO, LO, LO, 1'b0, NO_REPORT},
      '{LO, LO, LO, 1'b0, NO_REPORT},
      '{LO, LO, LO, 1'b0, NO_REPORT},
      '{LO, LO, LO, 1'b0, NO_REPORT},
      '{LO, LO, LO, 1'b0, NO_REPORT},
      '{LO, LO, LO, 1'b1, '{ST_ENDED, 15'd0, AXIS_X, ST_NONE}},
      '{HI, HI, HI, 1'b0, NO_REPORT},
      '{LO, LO, LO, 1'b0, NO_REPORT},
      '{HI, HI, HI, 1'b0, NO_REPORT},
      '{LO, LO, LO, 1'b0, NO_REPORT},
      '{RS, RS, RS, 1'b1, '{ST_NONE, 15'd0, AXIS_X, ST_ACTIVE}},
      '{HI, HI, HI, 1'b1, '{ST_NONE, 15'd0, AXIS_X, ST_ENDED}},
      '{LO, LO, LO, 1'b0, NO_REPORT},
      '{10'd5, 10'd900, 10'd900, 1'b0, NO_REPORT},
      '{10'd5, 10'd6, 10'd900, 1'b0, NO_REPORT},
      '{10'd900, 10'd5, 10'd5, 1'b0, NO_REPORT},
      '{HI, LO, HI, 1'b0, NO_REPORT}
   };

   phase_setting_t phase_settings [NUM_PHASES] = '{
      '{15'd15, 15'd10, 15'd338, 15'd160, 15'd320},
      '{15'd0, 15'd0, 15'd0, 15'd0, 15'd0},
      '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF},
      '{15'd40, 15'd20, 15'd512, 15'd400, 15'd300},
      '{15'd100, 15'd60, 15'd200, 15'd2000, 15'd6000},
      '{15'd5, 15'd3, 15'd338, 15'd28352, 15'd28352},
      '{15'd200, 15'd250, 15'd700, 15'd1000, 15'd500},
      '{15'h7C0F, 15'h440A, 15'h5552, 15'd160, 15'd320}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [9:0] abs_diff(logic [9:0] a, logic [9:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic logic [14:0] root_q4(logic [31:0] v);
      logic [14:0] root;
      logic [14:0] cand;
      root = '0;
      for (int b = 14; b >= 0; b--) begin
         cand = root | (15'd1 << b);
         if (32'(cand) * 32'(cand) <= v) root = cand;
      end
      return root;
   endfunction

   function automatic logic [14:0] mix_filtered(logic [14:0] mag);
      logic [31:0] acc;
      acc = 32'd6 * 32'(mag) + 32'd4 * 32'(filtered_q4) + 32'd5;
      return 15'(acc / 32'd10);
   endfunction

   function automatic shake_report_t predict_report(logic [9:0] ax, logic [9:0] ay,
                                                    logic [9:0] az);
      logic [9:0]    cur [3];
      logic [9:0]    d;
      logic [31:0]   sum_sq;
      logic [14:0]   mag;
      int            strong_axes;
      int            restless_axes;
      int            best;
      bit            hard_shake;
      bit            restless;
      shake_report_t r;
      cur = '{ax, ay, az};
      sum_sq = '0;
      strong_axes = 0;
      restless_axes = 0;
      for (int i = 0; i < 3; i++) begin
         d = abs_diff(cur[i], rest_level);
         sum_sq = sum_sq + 32'(d) * 32'(d);
         if (abs_diff(cur[i], prev_word[i]) > upper_thr) strong_axes++;
         if (abs_diff(cur[i], prev_word[i]) > lower_thr) restless_axes++;
      end
      mag = root_q4(sum_sq << 8);
      best = 0;
      if (cur[1] > cur[best]) best = 1;
      if (cur[2] > cur[best]) best = 2;
      r.axis = (best == 0) ? AXIS_X : (best == 1) ? AXIS_Y : AXIS_Z;
      hard_shake = strong_axes >= 2;
      restless = restless_axes >= 2;

      if (hard_shake && !shaking && !falling && shake_count == SHAKE_COUNT_MAX) begin
         shaking = 1'b1;
         filtered_q4 = mix_filtered(mag);
         r.status = ST_ACTIVE;
      end else begin
         if (hard_shake) begin
            if (shake_count < SHAKE_COUNT_MAX) shake_count++;
            filtered_q4 = mix_filtered(mag);
         end
         if (shaking && shake_count == 0) begin
            shaking = 1'b0;
            filtered_q4 = '0;
            r.status = ST_ENDED;
         end else begin
            if (!restless && shake_count > 0) shake_count--;
            r.status = shaking ? ST_ACTIVE : ST_NONE;
         end
      end

      if (!falling && mag < enter_level) begin
         falling = 1'b1;
         r.fall = ST_ACTIVE;
      end else if (falling && mag > exit_level) begin
         falling = 1'b0;
         r.fall = ST_ENDED;
      end else begin
         r.fall = falling ? ST_ACTIVE : ST_NONE;
      end

      prev_word = cur;
      r.strength = (r.status == ST_ACTIVE) ? filtered_q4 : 15'd0;
      return r;
   endfunction

   task automatic send_sample(input logic [9:0] ax, input logic [9:0] ay,
                              input logic [9:0] az, input bit typed,
                              input shake_report_t typed_report);
      shake_report_t predicted;
      req_valid   <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_report(ax, ay, az);
      expected_reports.push_back(typed ? typed_report : predicted);
      sent_word = '{ax, ay, az};
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(30, 1)) @(posedge clock);
         burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(12, 0);
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [14:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SHAKE_UPPER: upper_thr = data[9:0];
         CSR_SHAKE_LOWER: lower_thr = data[9:0];
         CSR_REST_LEVEL:  rest_level = data[9:0];
         CSR_FALL_ENTER:  enter_level = data;
         CSR_FALL_EXIT:   exit_level = data;
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int p);
      write_register(3'(CSR_UNUSED_LO + p % 3), 15'($urandom));
      write_register(CSR_SHAKE_UPPER, phase_settings[p].upper);
      write_register(CSR_SHAKE_LOWER, phase_settings[p].lower);
      write_register(CSR_REST_LEVEL, phase_settings[p].rest);
      write_register(CSR_FALL_ENTER, phase_settings[p].enter);
      write_register(CSR_FALL_EXIT, phase_settings[p].leave);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_reports.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic [9:0] far_from(int p, int thr);
      if (p >= 512 && p > thr) return 10'($urandom_range(p - thr - 1, 0));
      if (p < 512 && p + thr < 1023) return 10'($urandom_range(1023, p + thr + 1));
      return 10'($urandom_range(1023, 0));
   endfunction

   function automatic logic [9:0] near_to(int p, int span);
      int lo;
      int hi;
      lo = (p > span) ? p - span : 0;
      hi = (p + span < 1023) ? p + span : 1023;
      return 10'($urandom_range(hi, lo));
   endfunction

   // Mostly runs of strong movement, quiet jitter and near-rest words, with noise between.
   task automatic run_random(input int count);
      int         sent;
      int         kind;
      int         len;
      int         span;
      logic [9:0] w [3];
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(99, 0);
         len = $urandom_range(16, 3);
         for (int k = 0; k < len && sent < count; k++) begin
            span = ($urandom_range(3, 0) == 0) ? int'(upper_thr) : int'(lower_thr);
            for (int i = 0; i < 3; i++) begin
               if (kind < 40)
                  w[i] = ($urandom_range(99, 0) < 85) ? far_from(sent_word[i], upper_thr)
                                                      : near_to(sent_word[i], lower_thr);
               else if (kind < 70)
                  w[i] = near_to(sent_word[i], span);
               else if (kind < 85)
                  w[i] = near_to(rest_level, $urandom_range(12, 0));
               else
                  w[i] = 10'($urandom_range(1023, 0));
            end
            send_sample(w[0], w[1], w[2], 1'b0, NO_REPORT);
            sent++;
         end
      end
   endtask

   function automatic void check_field(input string name, input int exp, input int act);
      if (exp != act) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      shake_report_t exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected response word, expected none, actual %0d/%0d/%0d/%0d",
                     $time, rsp_shake_status, rsp_shake_strength, rsp_shake_axis,
                     rsp_fall_status);
            mismatch_count++;
         end else begin
            exp = expected_reports.pop_front();
            check_field("shake_status", exp.status, rsp_shake_status);
            check_field("shake_strength", exp.strength, rsp_shake_strength);
            check_field("shake_axis", exp.axis, rsp_shake_axis);
            check_field("fall_status", exp.fall, rsp_fall_status);
         end
      end
   end

   // The receiver switches between no, random, heavy and periodic stalling.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(3, 0);
         stall_span <= $urandom_range(200, 10);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(1, 0) == 1);
         2: rsp_stall <= ($urandom_range(9, 0) != 0);
         default: rsp_stall <= (cycle_count % 7) < 3;
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("shake_and_freefall_detector verification failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i])
         send_sample(directed_rows[i].ax, directed_rows[i].ay, directed_rows[i].az,
                     directed_rows[i].typed, directed_rows[i].report);
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         apply_setting(p);
         run_random(ITEMS_PER_PHASE);
      end
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("shake_and_freefall_detector verification clean");
      else
         $display("shake_and_freefall_detector verification failed");
      $finish;
   end

endmodule
`default_nettype wire
